@@ design/command_packet_deframer_unit_assert.svh @@
// Assertion macros for the deframer RTL.
`ifndef COMMAND_PACKET_DEFRAMER_UNIT_ASSERT_SVH
`define COMMAND_PACKET_DEFRAMER_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define CPD_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("deframer check failed");

`define CPD_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("deframer check failed");

`define CPD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("deframer check failed");

`else

`define CPD_ASSERT(lbl, prop)
`define CPD_ASSERT_IMP(lbl, ante, cons)
`define CPD_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

@@ design/cpd_pkg.sv @@
package cpd_pkg;

    localparam logic [7:0] SYNC_FIRST   = 8'hEA;
    localparam logic [7:0] SYNC_SECOND  = 8'hAE;
    localparam logic [7:0] TRAILER_BYTE = 8'hEE;

    localparam int unsigned TRAILER_LEN = 3;
    localparam int unsigned POS_W       = 4;

    localparam logic [POS_W-1:0] POS_SYNC_FIRST  = 4'd0;
    localparam logic [POS_W-1:0] POS_SYNC_SECOND = 4'd1;
    localparam logic [POS_W-1:0] POS_COMMAND     = 4'd2;
    localparam logic [POS_W-1:0] MIN_PACKET      = 4'd10;

    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
    localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_TOO_SHORT   = 2'd1,
        ST_BAD_SYNC    = 2'd2,
        ST_BAD_TRAILER = 2'd3
    } t_status;

    typedef enum logic {
        KIND_PAYLOAD = 1'b0,
        KIND_STATUS  = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] payload_byte;
        logic [7:0] command_code;
        t_status    status;
        logic       run_last;
    } t_result;

endpackage

@@ design/command_packet_deframer_unit.sv @@
// Channel  | Direction | Handshake          | Beat fields
// ---------+-----------+--------------------+-------------------------------------------
// input    | in        | i_valid / o_stall  | i_byte_in, i_end_of_packet
// result   | out       | o_valid / i_stall  | o_kind, o_payload_byte, o_command_code,
//          |           |                    | o_status, o_run_last
//
// One input beat per clock while o_stall is low; its results are formed in the same
// cycle and are registered in a four-entry result queue. A beat may yield two
// results; the queue drains one per clock while i_stall is low, so o_stall rises
// only when fewer than two free entries remain (queue depth sets this).
// Reset is synchronous, active low, and clears the packet state and the queue.
// i_stall only holds the queue head; input keeps flowing until o_stall rises.
module command_packet_deframer_unit
    import cpd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_byte_in,
    input  logic       i_end_of_packet,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_kind,
    output logic [7:0] o_payload_byte,
    output logic [7:0] o_command_code,
    output logic [1:0] o_status,
    output logic       o_run_last
);

`include "command_packet_deframer_unit_assert.svh"

    logic [POS_W-1:0] r_pos,     n_pos;
    logic             r_sync,    n_sync;
    logic [7:0]       r_cmd,     n_cmd;
    logic [7:0]       r_tail [TRAILER_LEN];
    logic [7:0]       n_tail [TRAILER_LEN];

    t_result          r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_count, n_count;

    logic    in_acc, out_acc;
    logic    release_pay, push1, push2;
    logic    sync_chk;
    logic [7:0] cmd_chk;
    t_status stat;
    t_result res_pay, res_stat, res_first;
    t_result head;
    logic    head_is_pay;

    assign in_acc  = i_valid && !o_stall;
    assign out_acc = o_valid && !i_stall;
    assign o_stall = (r_count > CNT_W'(FIFO_DEPTH - 2));
    assign o_valid = (r_count != '0);

    always_comb begin
        release_pay = (r_pos >= MIN_PACKET);
        sync_chk = r_sync;
        if (r_pos == POS_SYNC_FIRST && i_byte_in != SYNC_FIRST) begin
            sync_chk = 1'b0;
        end
        if (r_pos == POS_SYNC_SECOND && i_byte_in != SYNC_SECOND) begin
            sync_chk = 1'b0;
        end
        cmd_chk = (r_pos == POS_COMMAND) ? i_byte_in : r_cmd;

        if (r_pos < MIN_PACKET - 4'd1) begin
            stat = ST_TOO_SHORT;
        end else if (!sync_chk) begin
            stat = ST_BAD_SYNC;
        end else if (i_byte_in != TRAILER_BYTE || r_tail[0] != TRAILER_BYTE ||
                     r_tail[1] != TRAILER_BYTE) begin
            stat = ST_BAD_TRAILER;
        end else begin
            stat = ST_OK;
        end

        res_pay.kind         = KIND_PAYLOAD;
        res_pay.payload_byte = r_tail[TRAILER_LEN-1];
        res_pay.command_code = 8'd0;
        res_pay.status       = ST_OK;
        res_pay.run_last     = !i_end_of_packet;

        res_stat.kind         = KIND_STATUS;
        res_stat.payload_byte = 8'd0;
        res_stat.command_code = cmd_chk;
        res_stat.status       = stat;
        res_stat.run_last     = 1'b1;

        res_first = release_pay ? res_pay : res_stat;
        push1 = in_acc && (release_pay || i_end_of_packet);
        push2 = in_acc && release_pay && i_end_of_packet;
    end

    always_comb begin
        n_pos  = r_pos;
        n_sync = r_sync;
        n_cmd  = r_cmd;
        for (int k = 0; k < TRAILER_LEN; k++) begin
            n_tail[k] = r_tail[k];
        end
        if (in_acc) begin
            if (i_end_of_packet) begin
                n_pos  = '0;
                n_sync = 1'b1;
                n_cmd  = 8'd0;
                for (int k = 0; k < TRAILER_LEN; k++) begin
                    n_tail[k] = 8'd0;
                end
            end else begin
                n_sync = sync_chk;
                n_cmd  = cmd_chk;
                n_tail[0] = i_byte_in;
                for (int k = 1; k < TRAILER_LEN; k++) begin
                    n_tail[k] = r_tail[k-1];
                end
                if (r_pos < MIN_PACKET) begin
                    n_pos = r_pos + 4'd1;
                end
            end
        end
        n_count = r_count + CNT_W'(push1) + CNT_W'(push2) - CNT_W'(out_acc);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_sync  <= 1'b1;
            r_cmd   <= 8'd0;
            for (int k = 0; k < TRAILER_LEN; k++) begin
                r_tail[k] <= 8'd0;
            end
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_pos   <= n_pos;
            r_sync  <= n_sync;
            r_cmd   <= n_cmd;
            r_tail  <= n_tail;
            r_count <= n_count;
            r_wr    <= r_wr + PTR_W'(push1) + PTR_W'(push2);
            if (out_acc) begin
                r_rd <= r_rd + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push1) begin
            r_mem[r_wr] <= res_first;
        end
        if (push2) begin
            r_mem[r_wr + PTR_W'(1)] <= res_stat;
        end
    end

    assign head           = r_mem[r_rd];
    assign o_kind         = head.kind;
    assign o_payload_byte = head.payload_byte;
    assign o_command_code = head.command_code;
    assign o_status       = head.status;
    assign o_run_last     = head.run_last;
    assign head_is_pay    = o_valid && (o_kind == KIND_PAYLOAD);

    `CPD_ASSERT(a_count_bound, r_count <= CNT_W'(FIFO_DEPTH))
    `CPD_ASSERT(a_pos_saturates, r_pos <= MIN_PACKET)
    `CPD_ASSERT_IMP(a_room_on_accept, in_acc, r_count <= CNT_W'(FIFO_DEPTH - 2))
    `CPD_ASSERT_IMP(a_status_is_last, o_valid && o_kind == KIND_STATUS, o_run_last)
    `CPD_ASSERT_IMP(a_payload_clean, head_is_pay, o_status == ST_OK && o_command_code == 8'd0)
    `CPD_ASSERT_NEXT(a_eop_clears, in_acc && i_end_of_packet, r_pos == '0 && r_sync)

endmodule
